// ===== hw/rtl/addressed_packet_receiver_crc8_defines.svh =====
// Assertion macros for the addressed packet receiver.
`ifndef ADDRESSED_PACKET_RECEIVER_CRC8_DEFINES_SVH
`define ADDRESSED_PACKET_RECEIVER_CRC8_DEFINES_SVH
`ifndef SYNTH
`define APR_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define APR_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define APR_ASSERT_IMP(lbl, clk, rst, a, c)
`define APR_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

// ===== hw/rtl/apr_pkg.sv =====
// Package with constants and types of the addressed packet receiver.
`default_nettype none
package apr_pkg;
   localparam int MaxPayload = 60;
   localparam int MaxWrites = 21;
   localparam int PayIdxW = $clog2(MaxPayload);
   localparam int PayCntW = $clog2(MaxPayload + 1);

   localparam logic [1:0] KIND_WORD = 2'd0;
   localparam logic [1:0] KIND_TX = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;
   localparam logic [1:0] KIND_ACKNAK = 2'd3;

   localparam logic [2:0] ST_GOOD = 3'd0;
   localparam logic [2:0] ST_CRC_BAD = 3'd1;
   localparam logic [2:0] ST_WRONG_ADDR = 3'd2;
   localparam logic [2:0] ST_TOO_LONG = 3'd3;
   localparam logic [2:0] ST_ACK_CRC_BAD = 3'd4;

   localparam logic [1:0] REG_MODULE_ADDR = 2'd0;
   localparam logic [1:0] REG_MAX_DATA = 2'd1;
   localparam logic [1:0] REG_ACK_EN = 2'd2;
   localparam logic [1:0] REG_POLY = 2'd3;

   localparam logic [7:0] SYNC1_BYTE = 8'h06;
   localparam logic [7:0] SYNC2_BYTE = 8'h85;
   localparam logic [7:0] ACK_MARK = 8'hFF;
   localparam logic [7:0] ACK_CODE = 8'h01;
   localparam logic [7:0] NAK_CODE = 8'h02;
   localparam logic [7:0] REPLY_LEN = 8'h03;

   typedef struct packed {
      logic       start;
      logic [7:0] data;
      logic [7:0] init;
   } crc_req_type;
endpackage
`default_nettype wire

// ===== hw/rtl/apr_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module apr_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/apr_crc_unit.sv =====
// Bit-serial reflected CRC-8 unit, one bit per cycle.
`default_nettype none
module apr_crc_unit
   import apr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire crc_req_type req,
   input  wire logic [7:0]  poly,
   output logic             busy,
   output logic [7:0]       crc
);
   logic [7:0] crc_ff, crc_in, dat_ff, dat_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       fb;

   assign fb = crc_ff[0] ^ dat_ff[0];

   always_comb begin
      crc_in = crc_ff;
      dat_in = dat_ff;
      cnt_in = cnt_ff;
      if (req.start) begin
         crc_in = req.init;
         dat_in = req.data;
         cnt_in = 4'd8;
      end else if (cnt_ff != 4'd0) begin
         crc_in = (crc_ff >> 1) ^ (fb ? poly : 8'd0);
         dat_in = dat_ff >> 1;
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      crc_ff <= crc_in;
      dat_ff <= dat_in;
   end

   assign busy = (cnt_ff != 4'd0);
   assign crc = crc_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/addressed_packet_receiver_crc8.sv =====
// Top level of the addressed packet receiver with reflected CRC-8.
// A result word is registered and shows in the cycle after its byte. A plain byte keeps the
// sequencer idle, so the input is free while the output is; a byte fed to the CRC holds it until
// the shared CRC unit is done. A good-CRC packet ends with a word-emit sweep of the payload
// RAM (RD0, RDW, RD1, RD2 per triplet), then with replies on a reply CRC and 9 reply words.
// Reset is synchronous and active high; it sets the CSRs, error counters, state and rsp_valid.
`default_nettype none
`include "addressed_packet_receiver_crc8_defines.svh"
module addressed_packet_receiver_crc8
   import apr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_word_index,
   output logic [15:0]      rsp_word_value,
   output logic [7:0]       rsp_tx_byte,
   output logic [2:0]       rsp_packet_status,
   output logic [7:0]       rsp_peer_address,
   output logic [7:0]       rsp_ack_type,
   output logic [7:0]       rsp_echoed_crc,
   output logic [15:0]      rsp_align_errors,
   output logic [15:0]      rsp_crc_errors,
   output logic [15:0]      rsp_address_errors,
   output logic             rsp_last,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);
   // Sequencer states.
   localparam logic [3:0] S_IDLE = 4'd0;   // waiting for a byte
   localparam logic [3:0] S_CRC = 4'd1;    // payload byte through the CRC unit
   localparam logic [3:0] S_RD0 = 4'd2;    // read triplet index
   localparam logic [3:0] S_RD1 = 4'd3;    // read low byte
   localparam logic [3:0] S_RD2 = 4'd4;    // read high byte, emit write if index in range
   localparam logic [3:0] S_RC1 = 4'd5;    // reply CRC over the type byte
   localparam logic [3:0] S_RC2 = 4'd6;    // reply CRC over the echoed CRC
   localparam logic [3:0] S_TX = 4'd7;     // send the reply frame
   localparam logic [3:0] S_FIN = 4'd8;    // final status word
   localparam logic [3:0] S_RDW = 4'd9;    // RAM read latency for the index
   localparam logic [3:0] S_RC0 = 4'd10;   // reply CRC over the mark byte

   localparam logic [2:0] PH_SYNC1 = 3'd0;
   localparam logic [2:0] PH_SYNC2 = 3'd1;
   localparam logic [2:0] PH_DEST = 3'd2;
   localparam logic [2:0] PH_SRC = 3'd3;
   localparam logic [2:0] PH_LEN = 3'd4;
   localparam logic [2:0] PH_DATA = 3'd5;
   localparam logic [2:0] PH_ACK = 3'd6;

   logic [7:0] mod_addr_ff, max_addr_ff, poly_ff;
   logic       ack_en_ff;

   logic [3:0]  st_ff, st_in;
   logic [2:0]  ph_ff, ph_in;
   logic [7:0]  dest_ff, dest_in, src_ff, src_in, len_ff, len_in;
   logic [PayCntW-1:0] cnt_ff, cnt_in;
   logic [7:0]  rcrc_ff, rcrc_in;
   logic [7:0]  af1_ff, af1_in, af2_ff, af2_in;
   logic [15:0] align_ff, align_in, crce_ff, crce_in, adre_ff, adre_in;
   logic [15:0] dre_ff, dre_in;
   logic [7:0]  rxcrc_ff, rxcrc_in, rtype_ff, rtype_in;
   logic [PayCntW-1:0] rp_ff, rp_in;
   logic [4:0]  nw_ff, nw_in;
   logic [7:0]  idx_ff, idx_in, lo_ff, lo_in;
   logic [3:0]  txi_ff, txi_in;

   // Output register.
   logic        ov_ff, ov_in;
   logic [1:0]  ok_ff, ok_in;
   logic [7:0]  oi_ff, oi_in, ot_ff, ot_in, oat_ff, oat_in, oec_ff, oec_in;
   logic [15:0] ow_ff, ow_in;
   logic [2:0]  os_ff, os_in;
   logic        ol_ff, ol_in;

   crc_req_type crq;
   logic        crc_busy;
   logic [7:0]  crc_val;

   logic              ram_we;
   logic [PayIdxW-1:0] ram_addr;
   logic [7:0]        ram_q;

   logic out_free, acc;
   logic [7:0] b;

   apr_crc_unit u_crc (
      .clock(clock), .reset(reset), .req(crq), .poly(poly_ff),
      .busy(crc_busy), .crc(crc_val)
   );

   apr_ram #(.Width(8), .Depth(MaxPayload)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(req_rx_byte),
      .rd_data(ram_q)
   );

   assign out_free = !ov_ff || !rsp_stall;
   assign req_stall = (st_ff != S_IDLE) || !out_free;
   assign acc = req_valid && !req_stall;
   assign b = req_rx_byte;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [7:0] frame_byte(input logic [3:0] i,
         input logic [7:0] s, input logic [7:0] m, input logic [7:0] t,
         input logic [7:0] r, input logic [7:0] c);
      logic [7:0] v;
      v = c;
      unique case (i)
         4'd0: v = SYNC1_BYTE;
         4'd1: v = SYNC2_BYTE;
         4'd2: v = s;
         4'd3: v = m;
         4'd4: v = REPLY_LEN;
         4'd5: v = ACK_MARK;
         4'd6: v = t;
         4'd7: v = r;
         default: v = c;
      endcase
      return v;
   endfunction

   always_comb begin
      st_in = st_ff; ph_in = ph_ff; dest_in = dest_ff; src_in = src_ff;
      len_in = len_ff; cnt_in = cnt_ff; rcrc_in = rcrc_ff;
      af1_in = af1_ff; af2_in = af2_ff;
      align_in = align_ff; crce_in = crce_ff; adre_in = adre_ff; dre_in = dre_ff;
      rxcrc_in = rxcrc_ff; rtype_in = rtype_ff; rp_in = rp_ff; nw_in = nw_ff;
      idx_in = idx_ff; lo_in = lo_ff; txi_in = txi_ff;
      ov_in = ov_ff && rsp_stall;
      ok_in = ok_ff; oi_in = oi_ff; ow_in = ow_ff; ot_in = ot_ff; os_in = os_ff;
      oat_in = oat_ff; oec_in = oec_ff; ol_in = ol_ff;
      crq = '{start: 1'b0, data: b, init: rcrc_ff};
      ram_we = 1'b0;
      ram_addr = cnt_ff[PayIdxW-1:0];

      unique case (st_ff)
         S_IDLE: begin
            if (acc) begin
               unique case (ph_ff)
                  PH_SYNC1: begin
                     if (b == SYNC1_BYTE) ph_in = PH_SYNC2;
                     else align_in = sat_inc(align_ff);
                  end
                  PH_SYNC2: ph_in = (b == SYNC2_BYTE) ? PH_DEST : PH_SYNC1;
                  PH_DEST: begin dest_in = b; ph_in = PH_SRC; end
                  PH_SRC: begin src_in = b; ph_in = PH_LEN; end
                  PH_LEN: begin
                     len_in = b; cnt_in = '0; rcrc_in = '0; ph_in = PH_SYNC1;
                     ok_in = KIND_STATUS; oi_in = '0; ow_in = '0; ot_in = '0;
                     oat_in = '0; oec_in = '0; ol_in = 1'b1;
                     if (dest_ff != mod_addr_ff) begin
                        adre_in = sat_inc(adre_ff);
                        ov_in = 1'b1; os_in = ST_WRONG_ADDR;
                     end else if (b == 8'd0) begin
                        ph_in = PH_SYNC1;
                     end else if (b > 8'(MaxPayload)) begin
                        ov_in = 1'b1; os_in = ST_TOO_LONG;
                     end else begin
                        ph_in = PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     if (cnt_ff == '0 && b == ACK_MARK) begin
                        crq = '{start: 1'b1, data: b, init: 8'd0};
                        cnt_in = PayCntW'(1); ph_in = PH_ACK;
                        st_in = S_CRC;
                     end else if ({{(8-PayCntW){1'b0}}, cnt_ff} < len_ff &&
                                  cnt_ff < PayCntW'(MaxPayload)) begin
                        ram_we = 1'b1;
                        crq = '{start: 1'b1, data: b, init: rcrc_ff};
                        cnt_in = cnt_ff + PayCntW'(1);
                        st_in = S_CRC;
                     end else begin
                        rxcrc_in = b; ph_in = PH_SYNC1;
                        rp_in = '0; nw_in = '0;
                        if (b == rcrc_ff) begin
                           rtype_in = ACK_CODE; st_in = S_RD0;
                        end else begin
                           crce_in = sat_inc(crce_ff);
                           rtype_in = NAK_CODE;
                           st_in = ack_en_ff ? S_RC0 : S_FIN;
                        end
                     end
                  end
                  PH_ACK: begin
                     if (cnt_ff < PayCntW'(3)) begin
                        if (cnt_ff == PayCntW'(1)) af1_in = b;
                        else af2_in = b;
                        crq = '{start: 1'b1, data: b, init: rcrc_ff};
                        cnt_in = cnt_ff + PayCntW'(1);
                        st_in = S_CRC;
                     end else begin
                        ph_in = PH_SYNC1; ov_in = 1'b1; ol_in = 1'b1;
                        oi_in = '0; ow_in = '0; ot_in = '0;
                        if (b == rcrc_ff) begin
                           ok_in = KIND_ACKNAK; os_in = ST_GOOD;
                           oat_in = af1_ff; oec_in = af2_ff;
                        end else begin
                           crce_in = sat_inc(crce_ff);
                           ok_in = KIND_STATUS; os_in = ST_ACK_CRC_BAD;
                           oat_in = '0; oec_in = '0;
                        end
                     end
                  end
                  default: ph_in = PH_SYNC1;
               endcase
            end
         end
         S_CRC: begin
            if (!crc_busy) begin
               rcrc_in = crc_val; st_in = S_IDLE;
            end
         end
         // Sweep of the payload RAM, one triplet per pass.
         S_RD0: begin
            if ({{(8-PayCntW){1'b0}}, rp_ff} + 8'd2 < len_ff &&
                rp_ff + PayCntW'(2) < PayCntW'(MaxPayload) &&
                nw_ff < 5'(MaxWrites)) begin
               ram_addr = rp_ff[PayIdxW-1:0];
               st_in = S_RDW;
            end else begin
               st_in = ack_en_ff ? S_RC0 : S_FIN;
            end
         end
         S_RDW: begin
            ram_addr = PayIdxW'(rp_ff + PayCntW'(1));
            idx_in = ram_q; st_in = S_RD1;
         end
         S_RD1: begin
            ram_addr = PayIdxW'(rp_ff + PayCntW'(2));
            lo_in = ram_q; st_in = S_RD2;
         end
         S_RD2: begin
            if (out_free) begin
               ram_addr = PayIdxW'(rp_ff + PayCntW'(2));
               nw_in = nw_ff + 5'd1; rp_in = rp_ff + PayCntW'(3);
               st_in = S_RD0;
               if (idx_ff < max_addr_ff) begin
                  ov_in = 1'b1; ok_in = KIND_WORD; oi_in = idx_ff;
                  ow_in = {ram_q, lo_ff}; ot_in = '0; os_in = ST_GOOD;
                  oat_in = '0; oec_in = '0; ol_in = 1'b0;
               end else begin
                  dre_in = sat_inc(dre_ff);
               end
            end else begin
               ram_addr = PayIdxW'(rp_ff + PayCntW'(2));
            end
         end
         S_RC0: begin
            crq = '{start: 1'b1, data: ACK_MARK, init: 8'd0};
            st_in = S_RC1; txi_in = '0;
         end
         S_RC1: begin
            if (!crc_busy) begin
               crq = '{start: 1'b1, data: rtype_ff, init: crc_val};
               st_in = S_RC2;
            end
         end
         S_RC2: begin
            if (!crc_busy) begin
               crq = '{start: 1'b1, data: rxcrc_ff, init: crc_val};
               st_in = S_TX;
            end
         end
         S_TX: begin
            if (!crc_busy && out_free) begin
               ov_in = 1'b1; ok_in = KIND_TX; oi_in = '0; ow_in = '0;
               ot_in = frame_byte(txi_ff, src_ff, mod_addr_ff, rtype_ff,
                                  rxcrc_ff, crc_val);
               os_in = ST_GOOD; oat_in = '0; oec_in = '0; ol_in = 1'b0;
               txi_in = txi_ff + 4'd1;
               if (txi_ff == 4'd8) st_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               ov_in = 1'b1; ok_in = KIND_STATUS; oi_in = '0; ow_in = '0;
               ot_in = '0; oat_in = '0; oec_in = '0; ol_in = 1'b1;
               os_in = (rtype_ff == ACK_CODE) ? ST_GOOD : ST_CRC_BAD;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_addr_ff <= 8'd0; max_addr_ff <= 8'd20; ack_en_ff <= 1'b0;
         poly_ff <= 8'd140;
         st_ff <= S_IDLE; ph_ff <= PH_SYNC1; dest_ff <= '0; src_ff <= '0;
         len_ff <= '0; cnt_ff <= '0; rcrc_ff <= '0;
         align_ff <= '0; crce_ff <= '0; adre_ff <= '0; dre_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_MODULE_ADDR: mod_addr_ff <= csr_data;
               REG_MAX_DATA: max_addr_ff <= csr_data;
               REG_ACK_EN: ack_en_ff <= csr_data[0];
               REG_POLY: poly_ff <= csr_data;
               default: ;
            endcase
         end
         st_ff <= st_in; ph_ff <= ph_in; dest_ff <= dest_in; src_ff <= src_in;
         len_ff <= len_in; cnt_ff <= cnt_in; rcrc_ff <= rcrc_in;
         align_ff <= align_in; crce_ff <= crce_in; adre_ff <= adre_in;
         dre_ff <= dre_in;
         ov_ff <= ov_in;
      end
      af1_ff <= af1_in; af2_ff <= af2_in; rxcrc_ff <= rxcrc_in;
      rtype_ff <= rtype_in; rp_ff <= rp_in; nw_ff <= nw_in; idx_ff <= idx_in;
      lo_ff <= lo_in; txi_ff <= txi_in;
      ok_ff <= ok_in; oi_ff <= oi_in; ow_ff <= ow_in; ot_ff <= ot_in;
      os_ff <= os_in; oat_ff <= oat_in; oec_ff <= oec_in; ol_ff <= ol_in;
   end

   // Counters ride on every word as they stand after the byte is handled.
   assign rsp_valid = ov_ff;
   assign rsp_kind = ok_ff;
   assign rsp_word_index = oi_ff;
   assign rsp_word_value = ow_ff;
   assign rsp_tx_byte = ot_ff;
   assign rsp_packet_status = os_ff;
   assign rsp_peer_address = src_ff;
   assign rsp_ack_type = oat_ff;
   assign rsp_echoed_crc = oec_ff;
   assign rsp_align_errors = align_ff;
   assign rsp_crc_errors = crce_ff;
   assign rsp_address_errors = adre_ff;
   assign rsp_last = ol_ff;

   `APR_ASSERT_IMP(a_no_accept_busy, clock, reset, st_ff != S_IDLE, req_stall)
   `APR_ASSERT_NXT(a_hold_stalled, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
   `APR_ASSERT_IMP(a_crc_idle_in_idle, clock, reset, st_ff == S_IDLE, !crc_busy)
endmodule
`default_nettype wire
